FILE: hdl/poc_pkg.sv
package poc_pkg;

  localparam int VALUE_BITS  = 7;
  localparam int RULE_DEPTH  = 2048;
  localparam int SEQ_DEPTH   = 256;

  localparam int VALUE_COUNT = 1 << VALUE_BITS;
  localparam int RULE_AW     = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int RULE_CW     = $clog2(RULE_DEPTH + 1);
  localparam int SEQ_AW      = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int SEQ_CW      = $clog2(SEQ_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_RULE  = 2'd0,
    MODE_ELEM  = 2'd1,
    MODE_CLEAR = 2'd2
  } poc_mode_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] second_value;
    logic                  last_element;
  } poc_req_t;

  typedef struct packed {
    logic                  in_order;
    logic [VALUE_BITS-1:0] middle_value;
    logic [SEQ_CW-1:0]     sequence_length;
    logic                  rules_dropped;
    logic                  elements_dropped;
  } poc_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic walk_step;
    logic load;
  } poc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic seq_end;
    logic all_issued;
    logic pipe_busy;
    logic out_full;
  } poc_stat_t;

endpackage

FILE: hdl/precedence_order_checker.sv
// Checks a sequence of values against stored "a before b" rules. Add-rule, clear-rule
// and ordinary element requests do not stall the input. An element request marking
// the last element stalls the input until its result is loaded: the rule memory is
// walked one rule per cycle through a three-stage read pipeline (rule memory, then
// position table and valid bits, then compare), and the result then waits if the
// previous one has not yet been taken. Position valid bits are flops cleared all at
// once, so no clearing pass follows reset.
module precedence_order_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  poc_pkg::poc_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output poc_pkg::poc_rsp_t  out_rsp_o
);

  poc_pkg::poc_cmd_t  cmd;
  poc_pkg::poc_stat_t stat;

  poc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  poc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

FILE: hdl/poc_ctrl.sv
module poc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  poc_pkg::poc_stat_t  stat_i,
  output poc_pkg::poc_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o.accept     = 1'b0;
    cmd_o.walk_step  = 1'b0;
    cmd_o.load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.seq_end) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat_i.all_issued) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait until the output register can take the result
        if (!stat_i.out_full) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/poc_datapath.sv
module poc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  poc_pkg::poc_req_t   req_i,
  input  poc_pkg::poc_cmd_t   cmd_i,
  output poc_pkg::poc_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output poc_pkg::poc_rsp_t   rsp_o
);

  localparam int VB  = poc_pkg::VALUE_BITS;
  localparam int RAW = poc_pkg::RULE_AW;
  localparam int RCW = poc_pkg::RULE_CW;
  localparam int SAW = poc_pkg::SEQ_AW;
  localparam int SCW = poc_pkg::SEQ_CW;

  logic mode_rule, mode_elem, mode_clear;
  logic rule_room, elem_room, rule_we, elem_we, seq_end;

  logic [RCW-1:0] rule_count_q, widx_q;
  logic           rule_ovf_q;
  logic [SCW-1:0] elem_count_q, mid_idx;
  logic           elem_ovf_q;
  logic [poc_pkg::VALUE_COUNT-1:0] pvalid_q;

  logic           s1_q, s2_q, viol_q, out_valid_q;

  logic [2*VB-1:0] rule_mem [poc_pkg::RULE_DEPTH];
  logic [SAW-1:0]  ptab_mem [poc_pkg::VALUE_COUNT];
  logic [VB-1:0]   ebuf_mem [poc_pkg::SEQ_DEPTH];

  logic [2*VB-1:0] rule_rd_q;
  logic [SAW-1:0]  pa_q, pb_q;
  logic            va_q, vb_q;
  logic [VB-1:0]   mid_q;
  logic [VB-1:0]   ra, rb;
  poc_pkg::poc_rsp_t rsp_q;

  assign mode_rule  = (req_i.mode == poc_pkg::MODE_RULE);
  assign mode_elem  = (req_i.mode == poc_pkg::MODE_ELEM);
  assign mode_clear = (req_i.mode == poc_pkg::MODE_CLEAR);
  assign seq_end    = mode_elem && req_i.last_element;

  assign rule_room = (rule_count_q < RCW'(poc_pkg::RULE_DEPTH));
  assign elem_room = (elem_count_q < SCW'(poc_pkg::SEQ_DEPTH));
  assign rule_we   = cmd_i.accept && mode_rule && rule_room;
  assign elem_we   = cmd_i.accept && mode_elem && elem_room;

  assign mid_idx = elem_count_q >> 1;
  assign ra      = rule_rd_q[2*VB-1:VB];
  assign rb      = rule_rd_q[VB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
      rule_ovf_q   <= 1'b0;
      elem_count_q <= '0;
      elem_ovf_q   <= 1'b0;
      pvalid_q     <= '0;
      widx_q       <= '0;
      viol_q       <= 1'b0;
      s1_q         <= 1'b0;
      s2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && mode_clear) begin
        rule_count_q <= '0;
        rule_ovf_q   <= 1'b0;
      end else if (rule_we) begin
        rule_count_q <= rule_count_q + RCW'(1);
      end else if (cmd_i.accept && mode_rule) begin
        rule_ovf_q <= 1'b1;
      end

      if (cmd_i.load) begin
        elem_count_q <= '0;
        elem_ovf_q   <= 1'b0;
        pvalid_q     <= '0;
      end else if (elem_we) begin
        elem_count_q            <= elem_count_q + SCW'(1);
        pvalid_q[req_i.first_value] <= 1'b1;
      end else if (cmd_i.accept && mode_elem) begin
        elem_ovf_q <= 1'b1;
      end

      if (cmd_i.accept && seq_end) begin
        widx_q <= '0;
        viol_q <= 1'b0;
      end else begin
        if (cmd_i.walk_step) begin
          widx_q <= widx_q + RCW'(1);
        end
        if (s2_q && va_q && vb_q && (pa_q > pb_q)) begin
          viol_q <= 1'b1;
        end
      end

      s1_q        <= cmd_i.walk_step;
      s2_q        <= s1_q;
      out_valid_q <= cmd_i.load || (out_valid_q && out_stall_i);
    end
  end

  // rule store: one write port, one registered read port for the walk
  always_ff @(posedge clk_i) begin
    if (rule_we) begin
      rule_mem[rule_count_q[RAW-1:0]] <= {req_i.first_value, req_i.second_value};
    end
    rule_rd_q <= rule_mem[widx_q[RAW-1:0]];
  end

  // position table: two registered read ports for the rule's two values
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      ptab_mem[req_i.first_value] <= elem_count_q[SAW-1:0];
    end
    pa_q <= ptab_mem[ra];
    pb_q <= ptab_mem[rb];
    va_q <= pvalid_q[ra];
    vb_q <= pvalid_q[rb];
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      ebuf_mem[elem_count_q[SAW-1:0]] <= req_i.first_value;
    end
    mid_q <= ebuf_mem[mid_idx[SAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsp_q.in_order         <= !viol_q;
      rsp_q.middle_value     <= mid_q;
      rsp_q.sequence_length  <= elem_count_q;
      rsp_q.rules_dropped    <= rule_ovf_q;
      rsp_q.elements_dropped <= elem_ovf_q;
    end
  end

  assign stat_o.seq_end    = seq_end;
  assign stat_o.all_issued = (widx_q == rule_count_q);
  assign stat_o.pipe_busy  = s1_q || s2_q;
  assign stat_o.out_full   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!s1_q && !s2_q))
    else $error("result loaded while rule walk still in flight");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> (widx_q < rule_count_q))
    else $error("walk index past rule count");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rule_count_q <= RCW'(poc_pkg::RULE_DEPTH)) &&
    (elem_count_q <= SCW'(poc_pkg::SEQ_DEPTH)))
    else $error("store count exceeds capacity");

  a_seq_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> ((elem_count_q == '0) && (pvalid_q == '0) && !elem_ovf_q))
    else $error("sequence state not cleared after result");

  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && seq_end) |=> ((widx_q == '0) && !viol_q))
    else $error("walk did not restart at sequence end");

endmodule

FILE: test/precedence_order_checker_test.sv
module precedence_order_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         RANDOM_ITEMS = 500;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall_o;
  poc_pkg::poc_req_t in_req      = '0;
  logic              out_valid_o;
  logic              out_stall   = 1'b0;
  poc_pkg::poc_rsp_t out_rsp_o;

  precedence_order_checker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // requests waiting to be offered, verdicts waiting to come out
  poc_pkg::poc_req_t pending_q[$];
  poc_pkg::poc_rsp_t verdict_q[$];

  // shadow of the checker state
  logic [poc_pkg::VALUE_BITS-1:0] rule_a   [poc_pkg::RULE_DEPTH];
  logic [poc_pkg::VALUE_BITS-1:0] rule_b   [poc_pkg::RULE_DEPTH];
  int                             rule_cnt = 0;
  bit                             rule_ovf = 1'b0;
  logic [poc_pkg::SEQ_AW-1:0]     pos_tab  [poc_pkg::VALUE_COUNT];
  bit                             pos_vld  [poc_pkg::VALUE_COUNT] = '{default: 1'b0};
  logic [poc_pkg::VALUE_BITS-1:0] elem_buf [poc_pkg::SEQ_DEPTH];
  int                             elem_cnt = 0;
  bit                             elem_ovf = 1'b0;

  int mismatch_cnt = 0;
  int results_seen = 0;
  int cycle_cnt    = 0;

  task automatic predict_order_verdict(input poc_pkg::poc_req_t req);
    poc_pkg::poc_rsp_t rsp;
    bit                ok;
    int                mid;
    case (req.mode)
      poc_pkg::MODE_RULE: begin
        if (rule_cnt < poc_pkg::RULE_DEPTH) begin
          rule_a[rule_cnt] = req.first_value;
          rule_b[rule_cnt] = req.second_value;
          rule_cnt++;
        end else begin
          rule_ovf = 1'b1;
        end
      end
      poc_pkg::MODE_CLEAR: begin
        rule_cnt = 0;
        rule_ovf = 1'b0;
      end
      poc_pkg::MODE_ELEM: begin
        if (elem_cnt < poc_pkg::SEQ_DEPTH) begin
          elem_buf[elem_cnt]          = req.first_value;
          pos_tab[req.first_value]    = elem_cnt[poc_pkg::SEQ_AW-1:0];
          pos_vld[req.first_value]    = 1'b1;
          elem_cnt++;
        end else begin
          elem_ovf = 1'b1;
        end
        if (req.last_element) begin
          ok = 1'b1;
          for (int r = 0; r < rule_cnt; r++) begin
            if (pos_vld[rule_a[r]] && pos_vld[rule_b[r]] &&
                pos_tab[rule_a[r]] > pos_tab[rule_b[r]]) ok = 1'b0;
          end
          mid = elem_cnt / 2;
          rsp.in_order         = ok;
          rsp.middle_value     = (mid < elem_cnt) ? elem_buf[mid] : '0;
          rsp.sequence_length  = elem_cnt[poc_pkg::SEQ_CW-1:0];
          rsp.rules_dropped    = rule_ovf;
          rsp.elements_dropped = elem_ovf;
          verdict_q.push_back(rsp);
          pos_vld  = '{default: 1'b0};
          elem_cnt = 0;
          elem_ovf = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic void push_req(logic [1:0] mode, int a, int b, bit last);
    poc_pkg::poc_req_t r;
    r.mode         = mode;
    r.first_value  = a[poc_pkg::VALUE_BITS-1:0];
    r.second_value = b[poc_pkg::VALUE_BITS-1:0];
    r.last_element = last;
    pending_q.push_back(r);
  endfunction

  function automatic void push_elem(int v, bit last);
    push_req(poc_pkg::MODE_ELEM, v, $urandom_range(0, poc_pkg::VALUE_COUNT - 1), last);
  endfunction

  function automatic void push_rule(int a, int b);
    push_req(poc_pkg::MODE_RULE, a, b, $urandom_range(0, 1));
  endfunction

  // mostly a narrow pool so rules actually hit the sequence
  function automatic int pick_value();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 15);
    return $urandom_range(0, poc_pkg::VALUE_COUNT - 1);
  endfunction

  // ---------------- driver ----------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) predict_order_verdict(in_req);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_req   <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  poc_pkg::poc_rsp_t want_rsp;
  int                hold_left    = 0;
  bit                hold_done    = 1'b0;
  int                pattern_left = 0;
  int                stall_pct    = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected verdict: expected none, actual %h", $time, out_rsp_o);
          mismatch_cnt++;
        end else begin
          want_rsp = verdict_q.pop_front();
          check_field("in_order", want_rsp.in_order, out_rsp_o.in_order);
          check_field("middle_value", want_rsp.middle_value, out_rsp_o.middle_value);
          check_field("sequence_length", want_rsp.sequence_length,
                      out_rsp_o.sequence_length);
          check_field("rules_dropped", want_rsp.rules_dropped, out_rsp_o.rules_dropped);
          check_field("elements_dropped", want_rsp.elements_dropped,
                      out_rsp_o.elements_dropped);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (results_seen >= 20 && !hold_done) begin
        // long back-pressure so the checker fills and stalls its input
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 2))
            0:       stall_pct <= 0;
            1:       stall_pct <= 30;
            default: stall_pct <= 75;
          endcase
          pattern_left <= 64;
        end else begin
          pattern_left <= pattern_left - 1;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------- stimulus ----------------
  initial begin
    int n;
    int len;
    int gen_rules;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed
    push_req(MODE_UNUSED, poc_pkg::VALUE_COUNT - 1, poc_pkg::VALUE_COUNT - 1, 1'b1);
    push_rule(5, 9);
    push_rule(9, 9);                       // equal values never violate
    push_rule(0, poc_pkg::VALUE_COUNT - 1);
    push_elem(0, 1'b0);
    push_elem(5, 1'b0);
    push_elem(9, 1'b0);
    push_elem(poc_pkg::VALUE_COUNT - 1, 1'b1);
    push_elem(9, 1'b0);                    // repeat: later position wins
    push_elem(5, 1'b0);
    push_elem(9, 1'b1);
    push_elem(poc_pkg::VALUE_COUNT - 1, 1'b0);  // violates 0 before max
    push_elem(0, 1'b1);
    push_elem(poc_pkg::VALUE_COUNT - 1, 1'b1);
    push_req(poc_pkg::MODE_CLEAR, 0, 0, 1'b0);
    push_elem(poc_pkg::VALUE_COUNT - 1, 1'b0);
    push_elem(0, 1'b1);
    push_rule(poc_pkg::VALUE_COUNT - 1, 0);
    push_rule(1, 2);                       // one side absent
    push_elem(1, 1'b0);
    push_elem(poc_pkg::VALUE_COUNT - 1, 1'b1);
    wait_drained();

    // capacity: rule store overflow, sequence buffer overflow
    push_req(poc_pkg::MODE_CLEAR, poc_pkg::VALUE_COUNT - 1, poc_pkg::VALUE_COUNT - 1, 1'b1);
    for (int i = 0; i < poc_pkg::RULE_DEPTH + 2; i++)
      push_rule($urandom_range(0, poc_pkg::VALUE_COUNT - 1),
                $urandom_range(0, poc_pkg::VALUE_COUNT - 1));
    for (int i = 0; i < poc_pkg::SEQ_DEPTH + 2; i++)
      push_elem($urandom_range(0, poc_pkg::VALUE_COUNT - 1), i == poc_pkg::SEQ_DEPTH + 1);
    for (int i = 0; i < poc_pkg::SEQ_DEPTH; i++)
      push_elem($urandom_range(0, poc_pkg::VALUE_COUNT - 1), i == poc_pkg::SEQ_DEPTH - 1);
    push_elem(3, 1'b0);
    push_elem(4, 1'b0);
    push_elem(5, 1'b1);
    push_req(poc_pkg::MODE_CLEAR, 0, poc_pkg::VALUE_COUNT - 1, 1'b0);
    push_elem(6, 1'b0);
    push_elem(7, 1'b1);
    wait_drained();

    // random
    n = 0;
    gen_rules = 0;
    while (n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:7]: begin
          push_req(poc_pkg::MODE_CLEAR, $urandom_range(0, poc_pkg::VALUE_COUNT - 1),
                   $urandom_range(0, poc_pkg::VALUE_COUNT - 1), $urandom_range(0, 1));
          gen_rules = 0;
          n++;
        end
        [8:24]: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) push_rule(pick_value(), pick_value());
          gen_rules += len;
          n += len;
        end
        [25:29]: begin
          if ($urandom_range(0, 1)) begin
            push_req(MODE_UNUSED, $urandom_range(0, poc_pkg::VALUE_COUNT - 1),
                     $urandom_range(0, poc_pkg::VALUE_COUNT - 1), $urandom_range(0, 1));
          end else begin
            push_elem(pick_value(), 1'b0);   // stray element joins the next sequence
            n++;
          end
        end
        default: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
          for (int i = 0; i < len; i++) push_elem(pick_value(), i == len - 1);
          n += len;
        end
      endcase
      if (gen_rules > 64) begin
        push_req(poc_pkg::MODE_CLEAR, 0, 0, 1'b0);
        gen_rules = 0;
        n++;
      end
    end
    wait_drained();
    repeat (rule_cnt + 20) @(posedge clk_i);

    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
